// ----- rtl/core/sap_pkg.sv -----
// shared types and constants for the stepper acceleration profile block
// no dependencies
package sap_pkg;

  localparam int POS_W  = 32;
  localparam int FRAC_W = 8;
  localparam int SPD_W  = 40;
  localparam int ACC_W  = 24;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int SQ_STEPS  = SPD_W;
  localparam int DIV_W     = 64;
  localparam int DEN_W     = 35;
  localparam int CNT_W     = 6;

  localparam logic [0:0] OP_TICK = 1'b0;
  localparam logic [0:0] OP_MOVE = 1'b1;

  localparam logic [1:0] REG_INIT_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_ACCELERATION  = 2'd2;

  localparam logic [31:0] INIT_INTERVAL_RST = 32'd244738048;
  localparam logic [31:0] MIN_INTERVAL_RST  = 32'd256000000;
  localparam logic [ACC_W-1:0] ACCEL_RST    = 24'd1;

  localparam logic [SPD_W-1:0] SPEED_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic [30:0]      STOP_MAX  = 31'h7FFF_FFFF;
  localparam logic [31:0]      RAMP_MAX  = 32'h7FFF_FFFF;
  localparam logic [DIV_W-1:0] SPD_NUM   = 64'd1000000 << (2 * FRAC_W);
  localparam int               SQ_SHIFT  = 2 * FRAC_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIV_STOP,
    ST_PLAN,
    ST_DIV_E13,
    ST_E13,
    ST_SPEED,
    ST_DIV_SPD,
    ST_FIN,
    ST_DONE
  } sap_state_t;

endpackage

// ----- rtl/core/sap_in_if.sv -----
// input channel of the stepper acceleration profile block
// depends on nothing
interface sap_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] target;

  modport source (output valid, output op, output target, input ready);
  modport sink   (input valid, input op, input target, output ready);
endinterface

// ----- rtl/core/sap_out_if.sv -----
// result channel of the stepper acceleration profile block
// depends on nothing
interface sap_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coils;
  logic               stepped;
  logic               running;
  logic signed [31:0] position;

  modport source (output valid, output coils, output stepped, output running,
                  output position, input ready);
  modport sink   (input valid, input coils, input stepped, input running,
                  input position, output ready);
endinterface

// ----- rtl/core/stepper_accel_profile.sv -----
// top level of the trapezoidal stepper profile generator
// depends on sap_pkg, sap_in_if and sap_out_if
//
// Each input transfer is a time tick or a move to an absolute target, and gives
// exactly one result transfer. A tick that does not step is answered without a
// replan. A step or a new target replans the profile: a bit-serial squarer for
// the stopping distance, then up to three passes of one shared radix-2 restoring
// divider (steps to stop, the interval update and the speed). One item is worked
// on at a time; the input is ready only while the sequencer is idle.
module stepper_accel_profile
  import sap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sap_in_if.sink            in_if,
  sap_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  sap_state_t state_r, state_nxt;

  logic [31:0]       init_r, min_r;
  logic [ACC_W-1:0]  accel_r;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        tgt_r, tgt_nxt;
  logic signed [31:0]      ramp_r, ramp_nxt;
  logic [31:0]             cur_r, cur_nxt;
  logic [31-FRAC_W:0]      period_r, period_nxt;
  logic signed [SPD_W-1:0] speed_r, speed_nxt;
  logic                    dir_r, dir_nxt;
  logic [31:0]             elapsed_r, elapsed_nxt;
  logic [3:0]              coil_r, coil_nxt;
  logic                    stepped_r, stepped_nxt;
  logic                    dneg_r, dneg_nxt;

  logic [SPD_W-1:0]   mul_b_r, mul_b_nxt;
  logic [2*SPD_W-1:0] mul_acc_r, mul_acc_nxt;
  logic [DIV_W-1:0]   div_num_r, div_num_nxt;
  logic [DEN_W-1:0]   div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]   div_den_r, div_den_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_coils_r, out_coils_nxt;
  logic               out_stepped_r, out_stepped_nxt;
  logic               out_running_r, out_running_nxt;
  logic [31:0]        out_pos_r, out_pos_nxt;

  // shared divider step
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_step;
  logic [DIV_W-1:0] num_step;

  logic [SPD_W-1:0]   mag;
  logic [2*SPD_W-1:0] acc_step;
  logic [POS_W-1:0]   pos_diff, mdist;
  logic               dist_zero, dist_neg;
  logic [30:0]        stop;
  logic signed [31:0] ramp_n;
  logic signed [33:0] d_val;
  logic [33:0]        abs_d;
  logic [31:0]        el_inc;
  logic [POS_W-1:0]   pos_step;
  logic [33:0]        grow;
  logic [31:0]        c_new;
  logic [SPD_W-1:0]   sp;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_INIT_INTERVAL: prdata = init_r;
      REG_MIN_INTERVAL:  prdata = min_r;
      REG_ACCELERATION:  prdata = {{(CFG_DW-ACC_W){1'b0}}, accel_r};
      default:           prdata = '0;
    endcase
  end

  assign in_if.ready     = (state_r == ST_IDLE);
  assign out_if.valid    = out_valid_r;
  assign out_if.coils    = out_coils_r;
  assign out_if.stepped  = out_stepped_r;
  assign out_if.running  = out_running_r;
  assign out_if.position = out_pos_r;

  assign rem_sh   = {div_rem_r, div_num_r[DIV_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, div_den_r});
  assign rem_step = q_bit ? DEN_W'(rem_sh - {1'b0, div_den_r}) : rem_sh[DEN_W-1:0];
  assign num_step = {div_num_r[DIV_W-2:0], q_bit};

  assign mag      = speed_r[SPD_W-1] ? SPD_W'(-speed_r) : speed_r;
  assign acc_step = {mul_acc_r[2*SPD_W-2:0], 1'b0}
                    + (mul_b_r[SPD_W-1] ? {{SPD_W{1'b0}}, mag} : '0);

  assign pos_diff  = tgt_r - pos_r;
  assign dist_zero = (pos_diff == '0);
  assign dist_neg  = pos_diff[POS_W-1];
  assign mdist     = dist_neg ? POS_W'(-pos_diff) : pos_diff;
  assign stop      = (div_num_r[DIV_W-1:31] != '0) ? STOP_MAX : div_num_r[30:0];

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    tgt_nxt         = tgt_r;
    ramp_nxt        = ramp_r;
    cur_nxt         = cur_r;
    period_nxt      = period_r;
    speed_nxt       = speed_r;
    dir_nxt         = dir_r;
    elapsed_nxt     = elapsed_r;
    coil_nxt        = coil_r;
    stepped_nxt     = stepped_r;
    dneg_nxt        = dneg_r;
    mul_b_nxt       = mul_b_r;
    mul_acc_nxt     = mul_acc_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    div_den_nxt     = div_den_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_coils_nxt   = out_coils_r;
    out_stepped_nxt = out_stepped_r;
    out_running_nxt = out_running_r;
    out_pos_nxt     = out_pos_r;
    ramp_n          = ramp_r;
    d_val           = '0;
    abs_d           = '0;
    el_inc          = elapsed_r + 32'd1;
    pos_step        = dir_r ? pos_r + POS_W'(1) : pos_r - POS_W'(1);
    grow            = '0;
    c_new           = cur_r;
    sp              = div_num_r[SPD_W-1:0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          stepped_nxt = 1'b0;
          state_nxt   = ST_DONE;
          mul_b_nxt   = mag;
          mul_acc_nxt = '0;
          cnt_nxt     = '0;
          if (in_if.op == OP_MOVE) begin
            if (in_if.target != tgt_r) begin
              tgt_nxt   = in_if.target;
              state_nxt = ST_SQ;
            end
          end else if (period_r != '0) begin
            elapsed_nxt = el_inc;
            if (el_inc >= {{FRAC_W{1'b0}}, period_r}) begin
              pos_nxt     = pos_step;
              coil_nxt    = 4'b0001 << pos_step[1:0];
              elapsed_nxt = '0;
              stepped_nxt = 1'b1;
              state_nxt   = ST_SQ;
            end
          end
        end
      end
      ST_SQ: begin
        mul_acc_nxt = acc_step;
        mul_b_nxt   = {mul_b_r[SPD_W-2:0], 1'b0};
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          div_num_nxt = DIV_W'(acc_step >> SQ_SHIFT);
          div_rem_nxt = '0;
          div_den_nxt = (accel_r == '0) ? DEN_W'(1) : DEN_W'(accel_r);
          cnt_nxt     = '0;
          state_nxt   = ST_DIV_STOP;
        end
      end
      ST_DIV_STOP, ST_DIV_E13, ST_DIV_SPD: begin
        div_num_nxt = num_step;
        div_rem_nxt = rem_step;
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          unique case (state_r)
            ST_DIV_STOP: state_nxt = ST_PLAN;
            ST_DIV_E13:  state_nxt = ST_E13;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_PLAN: begin
        if (dist_zero && stop <= 31'd1) begin
          period_nxt = '0;
          speed_nxt  = '0;
          ramp_nxt   = '0;
          state_nxt  = ST_DONE;
        end else begin
          if (!dist_zero) begin
            if (ramp_r > 0) begin
              if ({1'b0, stop} >= mdist || dir_r != !dist_neg) begin
                ramp_n = -$signed({1'b0, stop});
              end
            end else if (ramp_r < 0) begin
              if ({1'b0, stop} < mdist && dir_r == !dist_neg) begin
                ramp_n = -ramp_r;
              end
            end
          end
          if (ramp_n == 0) begin
            cur_nxt    = init_r;
            dir_nxt    = !dist_neg && !dist_zero;
            ramp_nxt   = 32'sd1;
            period_nxt = init_r[31:FRAC_W];
            state_nxt  = ST_SPEED;
          end else begin
            ramp_nxt    = ramp_n;
            d_val       = {ramp_n, 2'b00} + 34'sd1;
            abs_d       = d_val[33] ? 34'(-d_val) : d_val;
            dneg_nxt    = d_val[33];
            div_num_nxt = {31'b0, cur_r, 1'b0};
            div_rem_nxt = '0;
            div_den_nxt = {1'b0, abs_d};
            cnt_nxt     = '0;
            state_nxt   = ST_DIV_E13;
          end
        end
      end
      ST_E13: begin
        if (dneg_r) begin
          grow  = {2'b00, cur_r} + {1'b0, div_num_r[32:0]};
          c_new = (grow[33:32] != 2'b00) ? 32'hFFFF_FFFF : grow[31:0];
        end else begin
          c_new = cur_r - div_num_r[31:0];
        end
        if (c_new < min_r) begin
          c_new = min_r;
        end
        cur_nxt    = c_new;
        period_nxt = c_new[31:FRAC_W];
        if (ramp_r != $signed(RAMP_MAX)) begin
          ramp_nxt = ramp_r + 32'sd1;
        end
        state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        if (cur_r == '0) begin
          div_num_nxt = DIV_W'(SPEED_MAX);
          state_nxt   = ST_FIN;
        end else begin
          div_num_nxt = SPD_NUM;
          div_rem_nxt = '0;
          div_den_nxt = DEN_W'(cur_r);
          cnt_nxt     = '0;
          state_nxt   = ST_DIV_SPD;
        end
      end
      ST_FIN: begin
        speed_nxt = dir_r ? $signed(sp) : -$signed(sp);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_coils_nxt   = coil_r;
          out_stepped_nxt = stepped_r;
          out_running_nxt = (speed_r != '0) || !dist_zero;
          out_pos_nxt     = pos_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_r      <= INIT_INTERVAL_RST;
      min_r       <= MIN_INTERVAL_RST;
      accel_r     <= ACCEL_RST;
      pos_r       <= '0;
      tgt_r       <= '0;
      ramp_r      <= '0;
      cur_r       <= '0;
      period_r    <= '0;
      speed_r     <= '0;
      dir_r       <= 1'b0;
      elapsed_r   <= '0;
      coil_r      <= '0;
      stepped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      ramp_r      <= ramp_nxt;
      cur_r       <= cur_nxt;
      period_r    <= period_nxt;
      speed_r     <= speed_nxt;
      dir_r       <= dir_nxt;
      elapsed_r   <= elapsed_nxt;
      coil_r      <= coil_nxt;
      stepped_r   <= stepped_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_INIT_INTERVAL: init_r  <= pwdata;
          REG_MIN_INTERVAL:  min_r   <= pwdata;
          REG_ACCELERATION:  accel_r <= pwdata[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dneg_r        <= dneg_nxt;
    mul_b_r       <= mul_b_nxt;
    mul_acc_r     <= mul_acc_nxt;
    div_num_r     <= div_num_nxt;
    div_rem_r     <= div_rem_nxt;
    div_den_r     <= div_den_nxt;
    out_coils_r   <= out_coils_nxt;
    out_stepped_r <= out_stepped_nxt;
    out_running_r <= out_running_nxt;
    out_pos_r     <= out_pos_nxt;
  end

endmodule

// ----- verif/stepper_accel_profile_tb.sv -----
// testbench for stepper_accel_profile: random ticks and moves checked against a
// cycle-free profile predictor held in a scoreboard class
// depends on sap_pkg, sap_in_if, sap_out_if and the stepper_accel_profile rtl
`timescale 1ns / 100ps

module stepper_accel_profile_tb;
  import sap_pkg::*;

  localparam longint RAMP_LIM = 64'h7FFF_FFFF;
  localparam int     WDOG_LIM = 5000;

  typedef struct packed {
    logic [3:0]  coils;
    logic        stepped;
    logic        running;
    logic [31:0] position;
  } step_result_t;

  class sap_profile_sb;
    logic [31:0]     init_iv, min_iv;
    logic [23:0]     accel;
    logic [31:0]     pos, tgt, elapsed, period;
    longint unsigned interval;
    longint          ramp, speed;
    bit              dir_cw;
    logic [3:0]      coil;
    step_result_t    pending[$];
    int              errors, checked, steps, moves;

    function new();
      init_iv = INIT_INTERVAL_RST;
      min_iv = MIN_INTERVAL_RST;
      accel = ACCEL_RST;
      pos = '0; tgt = '0; elapsed = '0; period = '0;
      interval = 0; ramp = 0; speed = 0; dir_cw = 0; coil = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_INIT_INTERVAL: init_iv = v;
        REG_MIN_INTERVAL:  min_iv = v;
        REG_ACCELERATION:  accel = v[23:0];
        default: ;
      endcase
    endfunction

    function longint unsigned stop_count();
      logic [127:0] mag, quot;
      mag = (speed < 0) ? 128'(-speed) : 128'(speed);
      quot = (mag * mag) >> SQ_SHIFT;
      if (quot[127:64] != 0) quot = {64'd0, {64{1'b1}}};
      quot = quot / ((accel == 0) ? 128'd1 : 128'(accel));
      return (quot > 128'(RAMP_LIM)) ? RAMP_LIM : quot[63:0];
    endfunction

    function void replan();
      int              pos_diff;
      longint unsigned mdist, stop, sp, twice;
      longint          d;
      pos_diff = signed'(tgt - pos);
      mdist = (pos_diff < 0) ? 64'(-longint'(pos_diff)) : 64'(pos_diff);
      stop = stop_count();
      if (pos_diff == 0 && stop <= 1) begin
        period = 0; speed = 0; ramp = 0;
        return;
      end
      if (pos_diff != 0) begin
        if (ramp > 0) begin
          if (stop >= mdist || dir_cw != (pos_diff > 0)) ramp = -longint'(stop);
        end else if (ramp < 0) begin
          if (stop < mdist && dir_cw == (pos_diff > 0)) ramp = -ramp;
        end
      end
      if (ramp == 0) begin
        interval = 64'(init_iv);
        dir_cw = pos_diff > 0;
      end else begin
        d = 4 * ramp + 1;
        twice = 2 * interval;
        if (d > 0) begin
          interval = interval - twice / longint'(d);
        end else begin
          interval = interval + twice / longint'(-d);
          if (interval > 64'hFFFF_FFFF) interval = 64'hFFFF_FFFF;
        end
        if (interval < 64'(min_iv)) interval = 64'(min_iv);
      end
      if (ramp < RAMP_LIM) ramp++;
      period = 32'(interval >> FRAC_W);
      if (interval == 0) sp = 64'(SPEED_MAX);
      else sp = SPD_NUM / interval;
      if (sp > 64'(SPEED_MAX)) sp = 64'(SPEED_MAX);
      speed = dir_cw ? longint'(sp) : -longint'(sp);
    endfunction

    function void note_item(logic op, logic [31:0] target);
      step_result_t r;
      r.stepped = 0;
      if (op == OP_MOVE) begin
        moves++;
        if (target != tgt) begin
          tgt = target;
          replan();
        end
      end else if (period != 0) begin
        elapsed = elapsed + 1;
        if (elapsed >= period) begin
          pos = dir_cw ? pos + 1 : pos - 1;
          coil = 4'b0001 << pos[1:0];
          elapsed = 0;
          r.stepped = 1;
          steps++;
          replan();
        end
      end
      r.coils = coil;
      r.running = (speed != 0) || (tgt != pos);
      r.position = pos;
      pending.push_back(r);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: expected %p, got %p", checked, want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic pready;
  sap_in_if  in_ch();
  sap_out_if out_ch();

  sap_profile_sb sb;
  bit quiet;
  int stall, idle_cycles;

  stepper_accel_profile u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // input monitor, result checker and receiver stalls
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.op, in_ch.target);
    if (out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.coils, out_ch.stepped, out_ch.running, out_ch.position});
      stall = quiet ? 0 : $urandom_range(0, 15);
      out_ch.ready <= (stall == 0);
    end else if (stall > 0) begin
      stall = stall - 1;
      if (stall == 0) out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIM) begin
      $display("watchdog: no transfer for %0d cycles", WDOG_LIM);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [31:0] target);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.target <= target;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic random_items(int count);
    logic [31:0] t;
    repeat (count) begin
      if ($urandom_range(0, 99) < 87) begin
        send_item(OP_TICK, $urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: t = $urandom;
          1: t = sb.tgt;
          default: t = sb.pos + 32'($signed($urandom_range(0, 60)) - 30);
        endcase
        send_item(OP_MOVE, t);
      end
    end
  endtask

  initial begin
    logic [31:0] cfg_sets[6][3];
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.op = OP_TICK; in_ch.target = '0;
    out_ch.ready = 1'b1;
    stall = 0; idle_cycles = 0; quiet = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset profile, target extremes, same target, a tick before any move
    send_item(OP_TICK, 32'hFFFF_FFFF);
    send_item(OP_MOVE, 32'd0);
    send_item(OP_MOVE, 32'h7FFF_FFFF);
    send_item(OP_MOVE, 32'h7FFF_FFFF);
    send_item(OP_MOVE, 32'h8000_0000);
    send_item(OP_MOVE, 32'hFFFF_FFFF);
    send_item(OP_MOVE, 32'd0);
    drain();
    cfg_write(REG_INIT_INTERVAL, 32'd768);
    cfg_write(REG_MIN_INTERVAL, 32'd256);
    cfg_write(REG_ACCELERATION, 32'd0);
    send_item(OP_MOVE, 32'd12);
    repeat (12) send_item(OP_TICK, '0);
    send_item(OP_MOVE, 32'hFFFF_FFFA);
    repeat (4) send_item(OP_TICK, '0);
    drain();

    cfg_sets = '{
      '{32'd1024, 32'd256, 32'd16777215},
      '{32'd2048, 32'd512, 32'd1000},
      '{32'd256, 32'd256, 32'd1},
      '{32'hFFFF_FFFF, 32'd256, 32'd5},
      '{32'd1536, 32'hFFFF_FFFF, 32'd200},
      '{32'd2560, 32'd768, 32'd50000}
    };
    foreach (cfg_sets[p]) begin
      cfg_write(REG_INIT_INTERVAL, cfg_sets[p][0]);
      cfg_write(REG_MIN_INTERVAL, cfg_sets[p][1]);
      cfg_write(REG_ACCELERATION, cfg_sets[p][2]);
      quiet = (p % 3) == 1;
      random_items(225);
      drain();
    end

    $display("covered %0d results: %0d steps and %0d moves over %0d profile settings",
             sb.checked, sb.steps, sb.moves, 8);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sap_pkg.sv
rtl/core/sap_in_if.sv
rtl/core/sap_out_if.sv
rtl/core/stepper_accel_profile.sv
verif/stepper_accel_profile_tb.sv
